// ===== src/first_fit_heap_allocator_top_macros.svh =====
// Assertion macros used by the allocator top level.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_TOP_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// Check a property on aclk, held off while reset is asserted.
`define FFHA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// Check a property on aclk at every edge, reset included.
`define FFHA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define FFHA_ASSERT(lbl, prop, msg)
`define FFHA_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== src/ffha_pkg.sv =====
// Package with widths, status codes and shared types of the allocator.
package ffha_pkg;

    localparam int START_W = 21;
    localparam int SIZE_W  = 22;
    localparam int ARENA_W = 22;
    localparam int STAT_W  = 2;
    localparam int TDATA_IN_W  = 48;
    localparam int TDATA_OUT_W = 48;

    localparam int DEF_MAX_SEGMENTS = 64;
    localparam int DEF_HEADER_BYTES = 16;
    localparam int DEF_ARENA_LIMIT  = 2097152;

    localparam logic [ARENA_W-1:0] ARENA_MIN   = ARENA_W'(64);
    localparam logic [ARENA_W-1:0] ARENA_RESET = ARENA_W'(1048576);
    localparam logic [SIZE_W-1:0]  USED_MAX    = '1;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOFIT    = 2'd1;
    localparam logic [STAT_W-1:0] ST_BADFREE  = 2'd2;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // Commands to the slot pool.
    typedef struct packed {
        logic init;
        logic set_en;
        logic clr_en;
    } pool_cmd_t;

endpackage

// ===== src/first_fit_heap_allocator_top.sv =====
// Top level of the first-fit heap allocator: chain walker, segment RAM and result stage.
//
// The allocator keeps an arena as an address-ordered chain of segments held in one
// segment RAM (start, payload size, free flag, next link per entry) with a registered
// read. Each request beat walks the chain from entry 0, in three steps per segment
// visited (check, address, evaluate). An allocate that hits writes the hit entry as
// used, and when the hit segment is split it first writes the split-off remainder; an
// allocate refused because the arena is exhausted skips the walk. A free that matches
// a used segment merges the free segments that follow it, until the merge stops at a
// used segment or the chain end. One request is in work at a time; the next is taken
// in the cycle after the result moves into the output register, and a result held there
// by m_tready low stalls the next request at its output step. After reset, and after
// every cfg_we write of arena_bytes, the S_INIT state rebuilds entry 0 as a single free
// segment, during which no beat is taken.
module first_fit_heap_allocator_top #(
    parameter int MAX_SEGMENTS = ffha_pkg::DEF_MAX_SEGMENTS,
    parameter int HEADER_BYTES = ffha_pkg::DEF_HEADER_BYTES,
    parameter int ARENA_LIMIT  = ffha_pkg::DEF_ARENA_LIMIT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // arena_bytes register
    input  logic                             cfg_we,
    input  logic [ffha_pkg::ARENA_W-1:0]     cfg_wdata,
    // request channel
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [21:0] request_length, [42:22] payload_offset, [47:43] zero
    input  logic [ffha_pkg::TDATA_IN_W-1:0]  s_tdata,
    // [0] kind
    input  logic                             s_tuser,
    // result channel
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [1:0] status, [22:2] granted_offset, [44:23] used_bytes, [47:45] zero
    output logic [ffha_pkg::TDATA_OUT_W-1:0] m_tdata
);
    import ffha_pkg::*;

    `include "first_fit_heap_allocator_top_macros.svh"

    localparam int IW = $clog2(MAX_SEGMENTS);
    localparam int NW = IW + 1;
    localparam int EW = START_W + SIZE_W + 1 + NW;
    localparam logic [NW-1:0]     END_MARK = NW'(MAX_SEGMENTS);
    localparam logic [SIZE_W-1:0] HDR      = SIZE_W'(HEADER_BYTES);

    typedef enum logic [9:0] {
        S_INIT  = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_CHK   = 10'b0000000100,
        S_RD    = 10'b0000001000,
        S_EVAL  = 10'b0000010000,
        S_WR2   = 10'b0000100000,
        S_MCHK  = 10'b0001000000,
        S_MRD   = 10'b0010000000,
        S_MEVAL = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } state_t;

    state_t               state_reg, state_next;
    logic [NW-1:0]        idx_reg, idx_next;
    logic [NW-1:0]        steps_reg, steps_next;
    logic                 kind_reg, kind_next;
    logic [SIZE_W-1:0]    len_reg, len_next;
    logic [START_W-1:0]   off_reg, off_next;
    logic [IW-1:0]        cur_idx_reg, cur_idx_next;
    logic [START_W-1:0]   cur_start_reg, cur_start_next;
    logic [SIZE_W-1:0]    cur_size_reg, cur_size_next;
    logic [NW-1:0]        cur_next_reg, cur_next_next;
    logic [IW-1:0]        slot_reg, slot_next;
    logic [SIZE_W-1:0]    used_reg, used_next;
    logic [ARENA_W-1:0]   arena_reg, arena_next;
    logic                 m_valid_reg, m_valid_next;
    logic [STAT_W-1:0]    res_status_reg, res_status_next;
    logic [START_W-1:0]   res_grant_reg, res_grant_next;
    logic [SIZE_W-1:0]    res_used_reg, res_used_next;
    logic [STAT_W-1:0]    m_status_reg, m_status_next;
    logic [START_W-1:0]   m_grant_reg, m_grant_next;

    logic                 ram_we;
    logic [IW-1:0]        ram_waddr;
    logic [EW-1:0]        ram_wdata;
    logic [EW-1:0]        ram_rdata;
    logic [START_W-1:0]   rd_start;
    logic [SIZE_W-1:0]    rd_size;
    logic                 rd_free;
    logic [NW-1:0]        rd_next;

    pool_cmd_t            pool_cmd;
    logic [IW-1:0]        pool_clr_idx;
    logic [IW-1:0]        free_idx;
    logic                 free_valid;

    logic [SIZE_W-1:0]    rem;
    logic                 fits;
    logic                 split;
    logic [SIZE_W-1:0]    grant_size;
    logic [SIZE_W+1:0]    add_sum;
    logic [SIZE_W:0]      sub_amt;
    logic [SIZE_W:0]      payload_pos;
    logic [SIZE_W+1:0]    split_start;
    logic [31:0]          cfg_wide;
    logic [ARENA_W-1:0]   cfg_clamped;

    assign {rd_start, rd_size, rd_free, rd_next} = ram_rdata;

    ffha_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_SEGMENTS)
    ) u_seg_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg[IW-1:0]),
        .rdata (ram_rdata)
    );

    ffha_slot_pool #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_slot_pool (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (pool_cmd),
        .set_idx    (free_idx),
        .clr_idx    (pool_clr_idx),
        .free_idx   (free_idx),
        .free_valid (free_valid)
    );

    assign pool_clr_idx = idx_reg[IW-1:0];

    // Datapath terms of the segment just read.
    assign fits        = rd_free && (rd_size >= len_reg);
    assign rem         = rd_size - len_reg;
    assign split       = (rem > HDR) && free_valid;
    assign grant_size  = split ? len_reg : rd_size;
    assign add_sum     = {2'b00, used_reg} + {2'b00, grant_size} + {2'b00, HDR};
    assign sub_amt     = {1'b0, rd_size} + {1'b0, HDR};
    assign payload_pos = {2'b00, rd_start} + {1'b0, HDR};
    assign split_start = {3'b000, rd_start} + {2'b00, HDR} + {2'b00, len_reg};

    // Clamp the written arena size into its legal range.
    assign cfg_wide    = 32'(cfg_wdata);
    assign cfg_clamped = (cfg_wdata < ARENA_MIN) ? ARENA_MIN :
                         (cfg_wide > 32'(ARENA_LIMIT)) ? ARENA_W'(ARENA_LIMIT) : cfg_wdata;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    // Drive the beat from the output register so it holds while m_tready is low.
    assign m_tdata  = {3'b000, res_used_reg, m_grant_reg, m_status_reg};

    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        steps_next      = steps_reg;
        kind_next       = kind_reg;
        len_next        = len_reg;
        off_next        = off_reg;
        cur_idx_next    = cur_idx_reg;
        cur_start_next  = cur_start_reg;
        cur_size_next   = cur_size_reg;
        cur_next_next   = cur_next_reg;
        slot_next       = slot_reg;
        used_next       = used_reg;
        arena_next      = arena_reg;
        res_status_next = res_status_reg;
        res_grant_next  = res_grant_reg;
        res_used_next   = res_used_reg;
        m_status_next   = m_status_reg;
        m_grant_next    = m_grant_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = '0;
        pool_cmd        = '0;

        case (state_reg)
            S_INIT: begin
                // Rebuild the chain as one free segment.
                ram_we        = 1'b1;
                ram_waddr     = '0;
                ram_wdata     = {{START_W{1'b0}},
                                 (arena_reg > HDR) ? arena_reg - HDR : {SIZE_W{1'b0}},
                                 1'b1, END_MARK};
                pool_cmd.init = 1'b1;
                used_next     = HDR;
                state_next    = S_IDLE;
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    kind_next      = s_tuser;
                    len_next       = s_tdata[SIZE_W-1:0];
                    off_next       = s_tdata[SIZE_W +: START_W];
                    idx_next       = '0;
                    steps_next     = '0;
                    res_grant_next = '0;
                    if (s_tuser == KIND_ALLOC && used_reg >= arena_reg) begin
                        res_status_next = ST_NOFIT;
                        state_next      = S_OUT;
                    end else begin
                        state_next = S_CHK;
                    end
                end
            end
            S_CHK: begin
                if (steps_reg < END_MARK && idx_reg < END_MARK) begin
                    state_next = S_RD;
                end else begin
                    res_status_next = (kind_reg == KIND_ALLOC) ? ST_NOFIT : ST_BADFREE;
                    state_next      = S_OUT;
                end
            end
            S_RD: begin
                state_next = S_EVAL;
            end
            S_EVAL: begin
                cur_idx_next   = idx_reg[IW-1:0];
                cur_start_next = rd_start;
                cur_size_next  = rd_size;
                cur_next_next  = rd_next;
                if (kind_reg == KIND_ALLOC) begin
                    if (fits) begin
                        used_next       = (add_sum > {2'b00, USED_MAX}) ?
                                          USED_MAX : add_sum[SIZE_W-1:0];
                        res_status_next = ST_OK;
                        res_grant_next  = payload_pos[START_W-1:0];
                        if (split) begin
                            // Write the split-off remainder now, the hit entry next.
                            ram_we          = 1'b1;
                            ram_waddr       = free_idx;
                            ram_wdata       = {split_start[START_W-1:0], rem - HDR,
                                               1'b1, rd_next};
                            pool_cmd.set_en = 1'b1;
                            slot_next       = free_idx;
                            state_next      = S_WR2;
                        end else begin
                            ram_we     = 1'b1;
                            ram_waddr  = idx_reg[IW-1:0];
                            ram_wdata  = {rd_start, rd_size, 1'b0, rd_next};
                            state_next = S_OUT;
                        end
                    end else begin
                        idx_next   = rd_next;
                        steps_next = steps_reg + 1'b1;
                        state_next = S_CHK;
                    end
                end else begin
                    if (payload_pos == {2'b00, off_reg}) begin
                        if (rd_free) begin
                            res_status_next = ST_BADFREE;
                            state_next      = S_OUT;
                        end else begin
                            used_next       = ({1'b0, used_reg} > sub_amt) ?
                                              used_reg - sub_amt[SIZE_W-1:0] : '0;
                            res_status_next = ST_OK;
                            steps_next      = '0;
                            state_next      = S_MCHK;
                        end
                    end else begin
                        idx_next   = rd_next;
                        steps_next = steps_reg + 1'b1;
                        state_next = S_CHK;
                    end
                end
            end
            S_WR2: begin
                ram_we     = 1'b1;
                ram_waddr  = cur_idx_reg;
                ram_wdata  = {cur_start_reg, len_reg, 1'b0, {1'b0, slot_reg}};
                state_next = S_OUT;
            end
            S_MCHK: begin
                if (steps_reg < END_MARK && cur_next_reg < END_MARK) begin
                    idx_next   = cur_next_reg;
                    state_next = S_MRD;
                end else begin
                    // Write back the freed, merged segment.
                    ram_we     = 1'b1;
                    ram_waddr  = cur_idx_reg;
                    ram_wdata  = {cur_start_reg, cur_size_reg, 1'b1, cur_next_reg};
                    state_next = S_OUT;
                end
            end
            S_MRD: begin
                state_next = S_MEVAL;
            end
            S_MEVAL: begin
                if (rd_free) begin
                    // Absorb the follower and drop its slot.
                    cur_size_next   = cur_size_reg + rd_size + HDR;
                    cur_next_next   = rd_next;
                    pool_cmd.clr_en = 1'b1;
                    steps_next      = steps_reg + 1'b1;
                    state_next      = S_MCHK;
                end else begin
                    ram_we     = 1'b1;
                    ram_waddr  = cur_idx_reg;
                    ram_wdata  = {cur_start_reg, cur_size_reg, 1'b1, cur_next_reg};
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    res_used_next = used_reg;
                    m_status_next = res_status_reg;
                    m_grant_next  = res_grant_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_INIT;
            end
        endcase

        if (cfg_we) begin
            arena_next = cfg_clamped;
            state_next = S_INIT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_INIT;
            m_valid_reg <= 1'b0;
            arena_reg   <= ARENA_RESET;
            used_reg    <= HDR;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            arena_reg   <= arena_next;
            used_reg    <= used_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        steps_reg      <= steps_next;
        kind_reg       <= kind_next;
        len_reg        <= len_next;
        off_reg        <= off_next;
        cur_idx_reg    <= cur_idx_next;
        cur_start_reg  <= cur_start_next;
        cur_size_reg   <= cur_size_next;
        cur_next_reg   <= cur_next_next;
        slot_reg       <= slot_next;
        res_status_reg <= res_status_next;
        res_grant_reg  <= res_grant_next;
        res_used_reg   <= res_used_next;
        m_status_reg   <= m_status_next;
        m_grant_reg    <= m_grant_next;
    end

    `FFHA_ASSERT(a_walk_in_range, (state_reg == S_RD || state_reg == S_MRD) |-> (idx_reg < END_MARK), "chain walk reads beyond the segment table")
    `FFHA_ASSERT(a_wr2_follows_split, (state_reg == S_WR2) |-> ($past(state_reg) == S_EVAL), "second split write without a split")
    `FFHA_ASSERT(a_fail_no_grant, (m_tvalid && m_tdata[1:0] != ST_OK) |-> (m_tdata[22:2] == '0), "failed request carries a granted offset")
endmodule

// ===== src/ffha_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== src/ffha_slot_pool.sv =====
// Occupancy bits of the segment slots and first-free-slot search.
module ffha_slot_pool #(
    parameter int MAX_SEGMENTS = ffha_pkg::DEF_MAX_SEGMENTS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  ffha_pkg::pool_cmd_t             cmd,
    input  logic [$clog2(MAX_SEGMENTS)-1:0] set_idx,
    input  logic [$clog2(MAX_SEGMENTS)-1:0] clr_idx,
    output logic [$clog2(MAX_SEGMENTS)-1:0] free_idx,
    output logic                            free_valid
);
    import ffha_pkg::*;

    localparam int IW = $clog2(MAX_SEGMENTS);

    logic [MAX_SEGMENTS-1:0] occ_reg;
    logic [MAX_SEGMENTS-1:0] occ_next;
    logic [MAX_SEGMENTS-1:0] only_first;

    assign only_first = {{(MAX_SEGMENTS-1){1'b0}}, 1'b1};

    always_comb begin
        occ_next = occ_reg;
        if (cmd.init) begin
            occ_next = only_first;
        end else begin
            if (cmd.set_en) occ_next[set_idx] = 1'b1;
            if (cmd.clr_en) occ_next[clr_idx] = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= only_first;
        end else begin
            occ_reg <= occ_next;
        end
    end

    // Lowest clear bit wins.
    always_comb begin
        free_idx   = '0;
        free_valid = 1'b0;
        for (int i = MAX_SEGMENTS - 1; i >= 0; i--) begin
            if (!occ_reg[i]) begin
                free_idx   = IW'(i);
                free_valid = 1'b1;
            end
        end
    end
endmodule

// ===== sim/tb.sv =====
// Self-checking testbench of the first-fit heap allocator top level.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ffha_pkg::*;

    localparam int NSEG = DEF_MAX_SEGMENTS;
    localparam int HDR  = DEF_HEADER_BYTES;
    localparam int LIMIT_BYTES = DEF_ARENA_LIMIT;
    localparam int unsigned MASK21 = 32'h1F_FFFF;
    localparam int unsigned MASK22 = 32'h3F_FFFF;
    // Longest walk plus merge, with margin.
    localparam int SETTLE_CYCLES = 6 * NSEG + 40;

    typedef struct {
        logic [STAT_W-1:0]  status;
        logic [START_W-1:0] offset;
        logic [SIZE_W-1:0]  used;
    } alloc_result_t;

    typedef struct {
        logic        kind;
        int unsigned req_len;
        int unsigned rel_off;
        bit          typed;
        alloc_result_t res;
    } stim_row_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_we;
    logic [ARENA_W-1:0]     cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [TDATA_IN_W-1:0]  s_tdata;   // [21:0] request_length, [42:22] payload_offset
    logic                   s_tuser;   // [0] kind
    logic                   m_tvalid;
    logic                   m_tready;
    logic [TDATA_OUT_W-1:0] m_tdata;   // [1:0] status, [22:2] offset, [44:23] used_bytes

    first_fit_heap_allocator_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock: 10 ns period.
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // ---------------------------------------------------------------
    // Arena shadow: own copy of the segment chain and the arena size.
    // ---------------------------------------------------------------
    int unsigned arena_size;
    int unsigned seg_start [NSEG];
    int unsigned seg_size  [NSEG];
    bit          seg_free  [NSEG];
    int unsigned seg_next  [NSEG];
    bit          slot_busy [NSEG];
    int unsigned bytes_used;
    int unsigned live_offsets[$];

    // Rebuild the arena as one free segment.
    function automatic void arena_rebuild();
        for (int i = 0; i < NSEG; i++) begin
            seg_start[i] = 0;
            seg_size[i]  = 0;
            seg_free[i]  = 0;
            seg_next[i]  = 0;
            slot_busy[i] = 0;
        end
        seg_size[0]  = (arena_size > HDR) ? arena_size - HDR : 0;
        seg_free[0]  = 1;
        seg_next[0]  = NSEG;
        slot_busy[0] = 1;
        bytes_used   = HDR;
        live_offsets.delete();
    endfunction

    // Walk the chain first-fit; split and account like the block.
    function automatic alloc_result_t arena_alloc(int unsigned len);
        alloc_result_t r;
        int unsigned cur;
        int unsigned rem;
        int unsigned slot;
        longint unsigned sum;
        r = '{ST_NOFIT, '0, '0};
        cur = 0;
        if (bytes_used < arena_size) begin
            for (int steps = 0; steps < NSEG && cur < NSEG; steps++) begin
                if (seg_free[cur] && seg_size[cur] >= len) begin
                    rem  = seg_size[cur] - len;
                    slot = NSEG;
                    for (int i = NSEG - 1; i >= 0; i--)
                        if (!slot_busy[i]) slot = i;
                    seg_free[cur] = 0;
                    if (rem > HDR && slot < NSEG) begin
                        seg_start[slot] = (seg_start[cur] + HDR + len) & MASK21;
                        seg_size[slot]  = rem - HDR;
                        seg_free[slot]  = 1;
                        seg_next[slot]  = seg_next[cur];
                        slot_busy[slot] = 1;
                        seg_next[cur]   = slot;
                        seg_size[cur]   = len;
                    end
                    sum = longint'(bytes_used) + seg_size[cur] + HDR;
                    bytes_used = (sum > MASK22) ? MASK22 : int'(sum);
                    r.status = ST_OK;
                    r.offset = START_W'((seg_start[cur] + HDR) & MASK21);
                    break;
                end
                cur = seg_next[cur];
            end
        end
        r.used = SIZE_W'(bytes_used);
        return r;
    endfunction

    // Release a used segment and merge free segments that follow it.
    function automatic alloc_result_t arena_release(int unsigned off);
        alloc_result_t r;
        int unsigned cur;
        int unsigned nx;
        int unsigned amount;
        int steps;
        r = '{ST_BADFREE, '0, '0};
        cur = 0;
        for (steps = 0; steps < NSEG && cur < NSEG; steps++) begin
            if (seg_start[cur] + HDR == off) break;
            cur = seg_next[cur];
        end
        if (!(cur >= NSEG || steps >= NSEG || seg_free[cur])) begin
            r.status = ST_OK;
            seg_free[cur] = 1;
            amount = seg_size[cur] + HDR;
            bytes_used = (bytes_used > amount) ? bytes_used - amount : 0;
            nx = seg_next[cur];
            for (int k = 0; k < NSEG && nx < NSEG && seg_free[nx]; k++) begin
                seg_size[cur] += seg_size[nx] + HDR;
                seg_next[cur] = seg_next[nx];
                slot_busy[nx] = 0;
                nx = seg_next[cur];
            end
            foreach (live_offsets[i])
                if (live_offsets[i] == off) begin
                    live_offsets.delete(i);
                    break;
                end
        end
        r.used = SIZE_W'(bytes_used);
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Result checking
    // ---------------------------------------------------------------
    alloc_result_t pending_results[$];
    int fail_count = 0;

    always @(posedge aclk) begin
        alloc_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result beat, tdata %h", m_tdata);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[1:0] !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tdata[1:0]);
                    fail_count++;
                end
                if (m_tdata[22:2] !== want.offset) begin
                    $error("granted_offset: expected %0d, got %0d", want.offset,
                           m_tdata[22:2]);
                    fail_count++;
                end
                if (m_tdata[44:23] !== want.used) begin
                    $error("used_bytes: expected %0d, got %0d", want.used, m_tdata[44:23]);
                    fail_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Receiver: random back-pressure, plus a long hold-off on request.
    // ---------------------------------------------------------------
    bit ready_always = 0;
    bit holdoff_req  = 0;
    int stall_left   = 0;

    always @(negedge aclk) begin
        int r;
        if (holdoff_req) begin
            // Hold off long enough for the sender to back up behind a full block.
            holdoff_req <= 0;
            stall_left  <= 600;
            m_tready    <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (ready_always) begin
            m_tready <= 1'b1;
        end else begin
            r = $urandom_range(0, 19);
            if (r < 12) m_tready <= 1'b1;
            else if (r < 19) begin
                stall_left <= $urandom_range(0, 3);
                m_tready   <= 1'b0;
            end else begin
                stall_left <= $urandom_range(10, 40);
                m_tready   <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Sender
    // ---------------------------------------------------------------
    bit sender_no_gaps = 0;

    // Offer one request beat; on acceptance, predict and queue the result.
    // Enters and leaves at a falling edge.
    task automatic send_request(logic kind, int unsigned len, int unsigned off,
                                bit typed, alloc_result_t typed_res);
        int r;
        int gap;
        alloc_result_t want;
        gap = 0;
        if (!sender_no_gaps) begin
            r = $urandom_range(0, 19);
            if (r >= 17) gap = (r == 19) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {5'b0, off[20:0], len[21:0]};
        do @(posedge aclk); while (!s_tready);
        if (kind == KIND_ALLOC) want = arena_alloc(len & MASK22);
        else want = arena_release(off & MASK21);
        if (kind == KIND_ALLOC && want.status == ST_OK) live_offsets.push_back(want.offset);
        pending_results.push_back(typed ? typed_res : want);
        @(negedge aclk);
    endtask

    // Let every expected result drain, then let the block settle.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_arena(int unsigned value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value[21:0];
        @(negedge aclk);
        cfg_we <= 1'b0;
        arena_size = value & MASK22;
        if (arena_size < ARENA_MIN) arena_size = ARENA_MIN;
        if (arena_size > LIMIT_BYTES) arena_size = LIMIT_BYTES;
        arena_rebuild();
    endtask

    // One random request, mostly well formed against the live allocations.
    task automatic random_request();
        int r;
        int unsigned len;
        int unsigned off;
        alloc_result_t none;
        none = '{'0, '0, '0};
        r   = $urandom_range(0, 99);
        len = $urandom_range(0, MASK22);
        off = $urandom_range(0, MASK21);
        if (r < 55) begin
            r = $urandom_range(0, 19);
            if (r < 14) len = $urandom_range(0, 200);
            else if (r < 19) len = $urandom_range(0, arena_size / 3);
            send_request(KIND_ALLOC, len, off, 0, none);
        end else begin
            r = $urandom_range(0, 9);
            if (r < 8 && live_offsets.size() > 0)
                off = live_offsets[$urandom_range(0, live_offsets.size() - 1)];
            else if (r == 8 && live_offsets.size() > 0)
                off = live_offsets[0] + 1;
            send_request(KIND_FREE, len, off, 0, none);
        end
    endtask

    stim_row_t directed_rows[] = '{
        '{KIND_ALLOC, 0,       0,       1, '{ST_OK,      21'd16, 22'd32}},
        '{KIND_ALLOC, 2097152, 0,       1, '{ST_NOFIT,   21'd0,  22'd32}},
        '{KIND_ALLOC, 4194303, 0,       1, '{ST_NOFIT,   21'd0,  22'd32}},
        '{KIND_FREE,  0,       0,       1, '{ST_BADFREE, 21'd0,  22'd32}},
        '{KIND_FREE,  4194303, 2097151, 1, '{ST_BADFREE, 21'd0,  22'd32}},
        '{KIND_FREE,  0,       16,      1, '{ST_OK,      21'd0,  22'd16}},
        '{KIND_FREE,  0,       16,      1, '{ST_BADFREE, 21'd0,  22'd16}},
        '{KIND_ALLOC, 100,     2097151, 0, '{'0, '0, '0}},
        '{KIND_ALLOC, 0,       0,       0, '{'0, '0, '0}},
        '{KIND_ALLOC, 17,      0,       0, '{'0, '0, '0}},
        '{KIND_ALLOC, 1,       0,       0, '{'0, '0, '0}},
        '{KIND_FREE,  0,       148,     0, '{'0, '0, '0}},
        '{KIND_FREE,  0,       164,     0, '{'0, '0, '0}},
        '{KIND_FREE,  0,       16,      0, '{'0, '0, '0}},
        '{KIND_ALLOC, 150,     0,       0, '{'0, '0, '0}},
        '{KIND_ALLOC, 1048400, 0,       0, '{'0, '0, '0}},
        '{KIND_ALLOC, 4194303, 2097151, 0, '{'0, '0, '0}},
        '{KIND_FREE,  0,       17,      0, '{'0, '0, '0}}
    };

    // Arena sizes per random phase: over-range, below minimum, extremes, odd sizes.
    int unsigned phase_sizes[] = '{4194303, 0, 64, 2097152, 1000, 5000, 300, 65536};

    initial begin
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        m_tready  = 1'b0;
        arena_size = ARENA_RESET;
        arena_rebuild();
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].kind, directed_rows[i].req_len,
                         directed_rows[i].rel_off, directed_rows[i].typed,
                         directed_rows[i].res);

        foreach (phase_sizes[p]) begin
            drain_results();
            write_arena(phase_sizes[p]);
            sender_no_gaps = (p % 3 == 1);
            ready_always   = (p % 3 == 2);
            for (int n = 0; n < 185; n++) begin
                if (n == 40 && p % 2 == 0) holdoff_req = 1;
                if (n == 100) begin
                    // Sender waits until every outstanding result is back.
                    s_tvalid <= 1'b0;
                    wait (pending_results.size() == 0);
                    @(negedge aclk);
                end
                random_request();
            end
        end
        drain_results();

        if (fail_count == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #30ms;
        $display("FAIL");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+src
src/ffha_pkg.sv
src/ffha_ram.sv
src/ffha_slot_pool.sv
src/first_fit_heap_allocator_top.sv
sim/tb.sv
